// ----- rtl/multi_slot_volume_fade_engine_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the fade engine core.
// Shared helpers that wrap concurrent assertions on clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_VOLUME_FADE_ENGINE_CORE_DEFINES_SVH
`define MULTI_SLOT_VOLUME_FADE_ENGINE_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define MSVFE_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("fade engine check failed");

// A condition that implies another in the same cycle.
`define MSVFE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fade engine check failed");

`endif

// ----- rtl/msvfe_pkg.sv -----
// ----------------------------------------------------------------------------
// msvfe_pkg
// Types and codes shared by the fade engine cells, divider and core.
// ----------------------------------------------------------------------------
package msvfe_pkg;

	typedef logic [2:0] code_t;

	localparam code_t ACT_START    = 3'd0;
	localparam code_t ACT_TICK     = 3'd1;
	localparam code_t ACT_CANCEL   = 3'd2;
	localparam code_t ACT_FADE_ALL = 3'd3;
	localparam code_t ACT_STOP     = 3'd4;
	localparam code_t ACT_GONE     = 3'd5;

	localparam code_t KIND_VOLUME   = 3'd0;
	localparam code_t KIND_IN_DONE  = 3'd1;
	localparam code_t KIND_OUT_DONE = 3'd2;
	localparam code_t KIND_EMPTY    = 3'd3;
	localparam code_t KIND_ACCEPT   = 3'd4;
	localparam code_t KIND_REJECT   = 3'd5;
	localparam code_t KIND_CANCEL   = 3'd6;
	localparam code_t KIND_STOP     = 3'd7;

	localparam logic [10:0] TickMax  = 11'd2047;
	localparam logic [4:0]  DivSteps = 5'd16;

	typedef struct packed {
		logic        valid;
		logic [7:0]  player;
		logic [7:0]  outp;
		logic        fo;
		logic [10:0] done;
		logic [10:0] total;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic shift;
		logic load;
		logic wr_done;
		logic set_done;
		logic set_fo;
		logic clr_player;
	} cell_ctl_t;

	typedef struct packed {
		code_t       kind;
		logic [7:0]  player;
		logic [7:0]  outp;
		logic        has;
		logic [15:0] volume;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/msvfe_cell.sv -----
// ----------------------------------------------------------------------------
// msvfe_cell
// One table slot; it loads from its right neighbor when an entry is removed.
// ----------------------------------------------------------------------------
module msvfe_cell import msvfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cell_ctl_t   ctl,
	input  entry_t      nxt,
	input  entry_t      new_e,
	input  logic [10:0] wdone,
	output entry_t      e
);

	entry_t e_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
		end else begin
			priority if (ctl.clear) begin
				e_q <= '0;
			end else if (ctl.shift) begin
				e_q <= nxt;
			end else if (ctl.load) begin
				e_q <= new_e;
			end else begin
				if (ctl.wr_done) begin
					e_q.done <= wdone;
				end else if (ctl.set_done) begin
					e_q.done <= e_q.total;
				end
				if (ctl.set_fo) begin
					e_q.fo <= 1'b1;
				end
				if (ctl.clr_player) begin
					e_q.player <= 8'd0;
				end
			end
		end
	end

	assign e = e_q;

endmodule

// ----- rtl/msvfe_div.sv -----
// ----------------------------------------------------------------------------
// msvfe_div
// Restoring divider, one quotient bit per cycle, sixteen-bit quotient.
// ----------------------------------------------------------------------------
module msvfe_div import msvfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [26:0] num,
	input  logic [10:0] den,
	output div_stat_t   stat,
	output logic [15:0] quo
);

	logic [10:0] rem_q;
	logic [15:0] num_q;
	logic [10:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [11:0] trial;
	logic [11:0] diff;
	logic        ge;

	assign trial = {rem_q, num_q[15]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivSteps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[26:16];
			num_q <= num[15:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[10:0] : trial[10:0];
			num_q <= {num_q[14:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = num_q;

endmodule

// ----- rtl/multi_slot_volume_fade_engine_core.sv -----
// ----------------------------------------------------------------------------
// multi_slot_volume_fade_engine_core
// Ordered table of volume fades kept in a row of slot cells.
// ----------------------------------------------------------------------------
// The block takes one request at a time and accepts the next one only after the
// last result of the current one has moved into the output register. A start
// is either accepted or refused; all fade out, player gone, a cancel with player
// 0 and the unused codes finish without a table walk; a cancel or a stop walks
// the table entry by entry. A tick walks the table too: it computes a volume for
// each fade that is still running with the shared sixteen-step divider, and it
// retires each fade that has reached its end, with or without a volume first.
// Results pass through a holding register and an output register, and a slow
// consumer stalls the block only while both of them hold results.
module multi_slot_volume_fade_engine_core import msvfe_pkg::*; #(
	parameter int SLOTS        = 8,
	parameter int ACTIVE_LIMIT = 3,
	parameter int TICK_MS      = 33
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  player_id,
	input  logic [7:0]  output_id,
	input  logic        fade_out,
	input  logic [15:0] duration_ms,
	input  logic [15:0] master_volume,
	input  logic        muted,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  result_player,
	output logic [7:0]  result_output,
	output logic        has_player,
	output logic [15:0] volume,
	output logic        last
);

`include "multi_slot_volume_fade_engine_core_defines.svh"

	localparam int IW = $clog2(SLOTS);
	localparam int PW = $clog2(SLOTS + 1);
	localparam int RecShift = 16 + $clog2(TICK_MS);
	localparam logic [17:0] RecMul = 18'((64'd1 << RecShift) / TICK_MS + 1);

	typedef enum logic [10:0] {
		S_IDLE      = 11'b00000000001,
		S_DECODE    = 11'b00000000010,
		S_REJECT    = 11'b00000000100,
		S_START_FIN = 11'b00000001000,
		S_TICK_EVAL = 11'b00000010000,
		S_TICK_DIV  = 11'b00000100000,
		S_TICK_VOL  = 11'b00001000000,
		S_TICK_DONE = 11'b00010000000,
		S_CANCEL    = 11'b00100000000,
		S_STOP      = 11'b01000000000,
		S_FINISH    = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic [PW-1:0] ptr_q, ptr_d;

	code_t       act_q;
	logic [7:0]  pid_q;
	logic [7:0]  oid_q;
	logic        dir_q;
	logic [15:0] dur_q;
	logic [15:0] master_q;

	entry_t    cells [SLOTS];
	cell_ctl_t ctl   [SLOTS];
	entry_t    new_e;
	entry_t    cur;
	logic [SLOTS-1:0] v;
	logic [SLOTS-1:0] pmatch;
	logic [PW-1:0] cnt;
	logic [PW-1:0] newcnt;
	logic          ptr_end;
	logic          reject;
	logic [10:0]   done1;
	logic [10:0]   frac;
	logic [26:0]   prod;
	logic [33:0]   rec_prod;
	logic [15:0]   tick_q;

	logic        div_start;
	logic [26:0] div_num;
	logic [10:0] div_den;
	div_stat_t   div_stat;
	logic [15:0] quo;

	logic    emit_v, emit_ok, out_free;
	result_t emit_r, pend_q, out_q;
	logic    pend_v_q, out_valid_q, last_q;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		entry_t nxt;
		if (g < SLOTS - 1) begin : g_mid
			assign nxt = cells[g+1];
		end else begin : g_tail
			assign nxt = '0;
		end
		assign v[g]      = cells[g].valid;
		assign pmatch[g] = cells[g].valid && (cells[g].player == pid_q);
		msvfe_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl[g]),
			.nxt   (nxt),
			.new_e (new_e),
			.wdone (done1),
			.e     (cells[g])
		);
	end

	assign cnt     = PW'($countones(v));
	assign newcnt  = cnt + PW'(1);
	assign ptr_end = (ptr_q == PW'(SLOTS));
	assign cur     = ptr_end ? entry_t'('0) : cells[ptr_q[IW-1:0]];
	assign reject  = (pid_q == 8'd0) || (oid_q == 8'd0) || (|pmatch) || v[SLOTS-1];
	assign done1   = cur.done + 11'd1;
	assign frac    = cur.fo ? (cur.total - done1) : done1;
	assign prod    = {11'd0, master_q} * {16'd0, frac};

	assign rec_prod = {18'd0, dur_q} * {16'd0, RecMul};
	assign tick_q   = 16'(rec_prod >> RecShift);

	assign div_num = prod;
	assign div_den = cur.total;

	always_comb begin
		new_e        = '0;
		new_e.valid  = 1'b1;
		new_e.player = pid_q;
		new_e.outp   = oid_q;
		new_e.fo     = dir_q;
		new_e.total  = (|tick_q[15:11]) ? TickMax : tick_q[10:0];
	end

	msvfe_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.stat  (div_stat),
		.quo   (quo)
	);

	assign out_free = !out_valid_q || out_ready;
	assign emit_ok  = !pend_v_q || out_free;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		emit_v    = 1'b0;
		emit_r    = '0;
		div_start = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			ctl[i] = '0;
		end
		unique case (state_q)
			S_IDLE: begin
				ptr_d = '0;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (act_q)
					ACT_START:  state_d = reject ? S_REJECT : S_START_FIN;
					ACT_TICK:   state_d = S_TICK_EVAL;
					ACT_CANCEL: state_d = (pid_q == 8'd0) ? S_FINISH : S_CANCEL;
					ACT_FADE_ALL: begin
						for (int i = 0; i < SLOTS; i++) begin
							ctl[i].set_fo = v[i];
						end
						state_d = S_FINISH;
					end
					ACT_STOP: state_d = S_STOP;
					ACT_GONE: begin
						if (pid_q != 8'd0) begin
							for (int i = 0; i < SLOTS; i++) begin
								ctl[i].clr_player = pmatch[i];
							end
						end
						state_d = S_FINISH;
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_REJECT: begin
				emit_v        = 1'b1;
				emit_r.kind   = KIND_REJECT;
				emit_r.player = pid_q;
				emit_r.outp   = oid_q;
				if (emit_ok) begin
					state_d = S_FINISH;
				end
			end
			S_START_FIN: begin
				emit_v        = 1'b1;
				emit_r.kind   = KIND_ACCEPT;
				emit_r.player = pid_q;
				emit_r.outp   = oid_q;
				emit_r.has    = 1'b1;
				if (emit_ok) begin
					for (int i = 0; i < SLOTS; i++) begin
						ctl[i].load     = (PW'(i) == cnt);
						ctl[i].set_done = (i + ACTIVE_LIMIT) < int'(newcnt);
					end
					state_d = S_FINISH;
				end
			end
			S_TICK_EVAL: begin
				if (ptr_end || !cur.valid) begin
					if (!v[0]) begin
						emit_v      = 1'b1;
						emit_r.kind = KIND_EMPTY;
						if (emit_ok) begin
							state_d = S_FINISH;
						end
					end else begin
						state_d = S_FINISH;
					end
				end else if (cur.done < cur.total) begin
					for (int i = 0; i < SLOTS; i++) begin
						ctl[i].wr_done = (PW'(i) == ptr_q);
					end
					div_start = 1'b1;
					state_d   = S_TICK_DIV;
				end else begin
					state_d = S_TICK_DONE;
				end
			end
			S_TICK_DIV: begin
				if (div_stat.done) begin
					state_d = S_TICK_VOL;
				end
			end
			S_TICK_VOL: begin
				emit_v        = 1'b1;
				emit_r.kind   = KIND_VOLUME;
				emit_r.player = cur.player;
				emit_r.outp   = cur.outp;
				emit_r.has    = (cur.player != 8'd0);
				emit_r.volume = quo;
				if (emit_ok) begin
					if (cur.done >= cur.total) begin
						state_d = S_TICK_DONE;
					end else begin
						ptr_d   = ptr_q + PW'(1);
						state_d = S_TICK_EVAL;
					end
				end
			end
			S_TICK_DONE: begin
				emit_v        = 1'b1;
				emit_r.kind   = cur.fo ? KIND_OUT_DONE : KIND_IN_DONE;
				emit_r.player = cur.player;
				emit_r.outp   = cur.outp;
				emit_r.has    = (cur.player != 8'd0);
				if (emit_ok) begin
					for (int i = 0; i < SLOTS; i++) begin
						ctl[i].shift = (i >= int'(ptr_q));
					end
					state_d = S_TICK_EVAL;
				end
			end
			S_CANCEL: begin
				if (ptr_end || !cur.valid) begin
					state_d = S_FINISH;
				end else if ((cur.player == pid_q) && (cur.fo == dir_q)) begin
					emit_v        = 1'b1;
					emit_r.kind   = KIND_CANCEL;
					emit_r.player = pid_q;
					emit_r.outp   = cur.outp;
					emit_r.has    = 1'b1;
					if (emit_ok) begin
						for (int i = 0; i < SLOTS; i++) begin
							ctl[i].shift = (i >= int'(ptr_q));
						end
					end
				end else begin
					ptr_d = ptr_q + PW'(1);
				end
			end
			S_STOP: begin
				if (ptr_end || !cur.valid) begin
					for (int i = 0; i < SLOTS; i++) begin
						ctl[i].clear = 1'b1;
					end
					state_d = S_FINISH;
				end else begin
					emit_v        = 1'b1;
					emit_r.kind   = KIND_STOP;
					emit_r.player = cur.player;
					emit_r.outp   = cur.outp;
					emit_r.has    = (cur.player != 8'd0);
					if (emit_ok) begin
						ptr_d = ptr_q + PW'(1);
					end
				end
			end
			S_FINISH: begin
				if (!pend_v_q || out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q    <= action;
			pid_q    <= player_id;
			oid_q    <= output_id;
			dir_q    <= fade_out;
			dur_q    <= duration_ms;
			master_q <= muted ? 16'd0 : master_volume;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_v && emit_ok) begin
				if (pend_v_q) begin
					out_valid_q <= 1'b1;
				end
				pend_v_q <= 1'b1;
			end
			if ((state_q == S_FINISH) && pend_v_q && out_free) begin
				out_valid_q <= 1'b1;
				pend_v_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_v && emit_ok) begin
			if (pend_v_q) begin
				out_q  <= pend_q;
				last_q <= 1'b0;
			end
			pend_q <= emit_r;
		end
		if ((state_q == S_FINISH) && pend_v_q && out_free) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_q.kind;
	assign result_player = out_q.player;
	assign result_output = out_q.outp;
	assign has_player    = out_q.has;
	assign volume        = out_q.volume;
	assign last          = last_q;

	`MSVFE_ASSERT_ALWAYS(a_table_compact, ((v & (v + SLOTS'(1))) == '0))
	`MSVFE_ASSERT_IMPL(a_ready_no_pending, in_ready, !pend_v_q)
	`MSVFE_ASSERT_IMPL(a_div_start_idle, div_start, !div_stat.busy)
	`MSVFE_ASSERT_IMPL(a_div_done_waited, div_stat.done, (state_q == S_TICK_DIV))

endmodule
